@@ design/ttcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcs_pkg: shared types and constants for the text terminal
// Cell format, special character codes, operation codes and the control
// structs between the top level and the screen walk sequencer.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam int unsigned CELL_W    = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;
  localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic scroll;
    logic clear;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

@@ design/ttcs_ram.sv @@
// ----------------------------------------------------------------------------
// ttcs_ram: screen cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttcs_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [ttcs_pkg::CELL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [ttcs_pkg::CELL_W-1:0] rdata_o
);
  import ttcs_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ttcs_walk.sv @@
// ----------------------------------------------------------------------------
// ttcs_walk: screen walk sequencer
// Runs the power-up fill, the one-row scroll copy and the blank fills,
// one cell per cycle through the cell memory.
// ----------------------------------------------------------------------------
module ttcs_walk #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttcs_pkg::walk_cmd_t         cmd_i,
  input  logic [ttcs_pkg::COLOR_W-1:0] color_i,
  input  logic [ttcs_pkg::CELL_W-1:0] rdata_i,
  output ttcs_pkg::walk_stat_t        stat_o,
  output logic                        we_o,
  output logic [$clog2(SCREEN_COLUMNS*SCREEN_ROWS)-1:0] waddr_o,
  output logic [ttcs_pkg::CELL_W-1:0] wdata_o,
  output logic                        re_o,
  output logic [$clog2(SCREEN_COLUMNS*SCREEN_ROWS)-1:0] raddr_o
);
  import ttcs_pkg::*;

  localparam int unsigned CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [AW-1:0] COLS_A     = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - SCREEN_COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_0 = AW'(CELLS - SCREEN_COLUMNS);

  localparam logic [2:0] W_INIT  = 3'd0;
  localparam logic [2:0] W_IDLE  = 3'd1;
  localparam logic [2:0] W_COPY  = 3'd2;
  localparam logic [2:0] W_DRAIN = 3'd3;
  localparam logic [2:0] W_FILL  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          cp_wr_q, cp_wr_d;
  logic [AW-1:0] cp_addr_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cp_wr_d     = 1'b0;
    stat_o.busy = (state_q != W_IDLE);
    stat_o.done = 1'b0;
    we_o        = 1'b0;
    waddr_o     = ptr_q;
    wdata_o     = {color_i, BLANK_CODE};
    re_o        = 1'b0;
    raddr_o     = ptr_q + COLS_A;
    unique case (state_q)
      W_INIT: begin
        we_o    = 1'b1;
        wdata_o = RESET_CELL;
        ptr_d   = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          state_d = W_IDLE;
          ptr_d   = '0;
        end
      end
      W_IDLE: begin
        ptr_d = '0;
        if (cmd_i.scroll) begin
          state_d = W_COPY;
        end else if (cmd_i.clear) begin
          state_d = W_FILL;
        end
      end
      W_COPY: begin
        re_o    = 1'b1;
        cp_wr_d = 1'b1;
        we_o    = cp_wr_q;
        waddr_o = cp_addr_q;
        wdata_o = rdata_i;
        ptr_d   = ptr_q + 1'b1;
        if (ptr_q == LAST_COPY) begin
          state_d = W_DRAIN;
        end
      end
      W_DRAIN: begin
        we_o    = cp_wr_q;
        waddr_o = cp_addr_q;
        wdata_o = rdata_i;
        ptr_d   = LAST_ROW_0;
        state_d = W_FILL;
      end
      W_FILL: begin
        we_o  = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          stat_o.done = 1'b1;
          state_d     = W_IDLE;
          ptr_d       = '0;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_INIT;
      ptr_q   <= '0;
      cp_wr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cp_wr_q <= cp_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= ptr_q;
  end

endmodule

@@ design/text_terminal_cursor_scroll.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll: text screen with cursor and scrolling
// Screen of 16-bit cells (color high byte, character low byte) with a cursor,
// put character, clear and cell read operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (func, char_code, cell_index) are taken on in_valid_i while
//   in_stall_o is low; each beat gives exactly one output beat (cursor row and
//   column after the operation, cell value, scroll flag), held in an output
//   register while out_stall_i is high.
//   cfg channel writes text_color; write it only while the block is idle.
//   Steps per beat:
//     put without scroll, newline, unused func: cell written if a character,
//       result loaded straight into the output register
//     read: registered memory read, then the output register
//     put with scroll: copy one cell per cycle, then blank the last row
//     clear: blank every cell in the text color
//   Reset: the cell memory is filled with blanks in color 7, one cell per
//   cycle, all ROWS*COLS cells (2000 by default); in_stall_o stays high
//   meanwhile. Cursor goes home and text_color returns to 7.
//   A stalled output beat holds; a new input beat is taken only if the output
//   register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttcs_pkg::COLOR_W-1:0]   cfg_text_color_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ttcs_pkg::FUNC_W-1:0]    func_i,
  input  logic [ttcs_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [ttcs_pkg::IDX_W-1:0]     cell_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ttcs_pkg::ROW_OUT_W-1:0] cursor_row_o,
  output logic [ttcs_pkg::COL_OUT_W-1:0] cursor_column_o,
  output logic [ttcs_pkg::CELL_W-1:0]    cell_value_o,
  output logic                           scrolled_o
);
  import ttcs_pkg::*;

  localparam int unsigned CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(SCREEN_ROWS);
  localparam int unsigned CW    = $clog2(SCREEN_COLUMNS);
  localparam int unsigned IW    = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] COLS_A   = AW'(SCREEN_COLUMNS);
  localparam logic [RW:0]   ROWS_W   = (RW+1)'(SCREEN_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW:0]   COLS_W   = (CW+1)'(SCREEN_COLUMNS);
  localparam logic [IW:0]   CELLS_W  = (IW+1)'(CELLS);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_READ = 2'd1;
  localparam logic [1:0] T_WALK = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [COLOR_W-1:0] color_q;
  logic [RW-1:0]      row_q, row_d, row_nx;
  logic [CW-1:0]      col_q, col_d, col_nx;
  logic [RW:0]        row_wide_nx;
  logic [CW:0]        col_inc;
  logic               is_nl, put_scroll;
  logic               walk_scr_q, walk_scr_d;
  logic               inrange_q, inrange_d;
  logic [IW-1:0]      idx_w;
  logic [AW-1:0]      pos;
  logic               accept;
  logic               put_we, rd_re;

  logic               load;
  logic [CELL_W-1:0]  ld_cell;
  logic               ld_scr;

  logic                     out_valid_q;
  logic [ROW_OUT_W-1:0]     out_row_q;
  logic [COL_OUT_W-1:0]     out_col_q;
  logic [CELL_W-1:0]        out_cell_q;
  logic                     out_scr_q;

  walk_cmd_t          walk_cmd;
  walk_stat_t         walk_stat;
  logic               walk_we, walk_re;
  logic [AW-1:0]      walk_waddr, walk_raddr;
  logic [CELL_W-1:0]  walk_wdata;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != T_IDLE) || walk_stat.busy || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;

  assign idx_w = IW'(cell_index_i);
  assign pos   = AW'(AW'(row_q) * COLS_A) + AW'(col_q);
  assign is_nl = (char_code_i == NEWLINE_CODE);

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    if (is_nl || (col_inc == COLS_W)) begin
      col_nx      = '0;
      row_wide_nx = {1'b0, row_q} + 1'b1;
    end else begin
      col_nx      = col_inc[CW-1:0];
      row_wide_nx = {1'b0, row_q};
    end
    put_scroll = (row_wide_nx == ROWS_W);
    row_nx     = put_scroll ? LAST_ROW : row_wide_nx[RW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    walk_scr_d  = walk_scr_q;
    inrange_d   = inrange_q;
    walk_cmd    = '0;
    put_we      = 1'b0;
    rd_re       = 1'b0;
    load        = 1'b0;
    ld_cell     = '0;
    ld_scr      = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_PUT: begin
              put_we = !is_nl;
              row_d  = row_nx;
              col_d  = col_nx;
              if (put_scroll) begin
                walk_cmd.scroll = 1'b1;
                walk_scr_d      = 1'b1;
                state_d         = T_WALK;
              end else begin
                load = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              row_d          = '0;
              col_d          = '0;
              walk_cmd.clear = 1'b1;
              walk_scr_d     = 1'b0;
              state_d        = T_WALK;
            end
            FUNC_READ: begin
              rd_re     = 1'b1;
              inrange_d = ({1'b0, idx_w} < CELLS_W);
              state_d   = T_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      T_READ: begin
        load    = 1'b1;
        ld_cell = inrange_q ? ram_rdata : '0;
        state_d = T_IDLE;
      end
      T_WALK: begin
        if (walk_stat.done) begin
          load    = 1'b1;
          ld_scr  = walk_scr_q;
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  assign ram_we    = walk_we || put_we;
  assign ram_waddr = walk_we ? walk_waddr : pos;
  assign ram_wdata = walk_we ? walk_wdata : {color_q, char_code_i};
  assign ram_re    = walk_re || rd_re;
  assign ram_raddr = walk_re ? walk_raddr : idx_w[AW-1:0];

  ttcs_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ttcs_walk #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (walk_cmd),
    .color_i (color_q),
    .rdata_i (ram_rdata),
    .stat_o  (walk_stat),
    .we_o    (walk_we),
    .waddr_o (walk_waddr),
    .wdata_o (walk_wdata),
    .re_o    (walk_re),
    .raddr_o (walk_raddr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      color_q     <= COLOR_RESET;
      row_q       <= '0;
      col_q       <= '0;
      walk_scr_q  <= 1'b0;
      inrange_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      walk_scr_q  <= walk_scr_d;
      inrange_q   <= inrange_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_text_color_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_row_q  <= ROW_OUT_W'(row_d);
      out_col_q  <= COL_OUT_W'(col_d);
      out_cell_q <= ld_cell;
      out_scr_q  <= ld_scr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_column_o = out_col_q;
  assign cell_value_o    = out_cell_q;
  assign scrolled_o      = out_scr_q;

endmodule

@@ design/ttcs_checker.sv @@
// ----------------------------------------------------------------------------
// ttcs_checker: port-level checks for the text terminal
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module ttcs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [ttcs_pkg::FUNC_W-1:0]    func_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ttcs_pkg::COL_OUT_W-1:0] cursor_column_o,
  input logic [ttcs_pkg::CELL_W-1:0]    cell_value_o,
  input logic                           scrolled_o
);
  import ttcs_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_value_o)
      && $stable(scrolled_o))
    else $error("stalled output beat changed");

  // a scroll always leaves the cursor at column zero
  a_scroll_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_column_o == '0)
    else $error("scroll with nonzero column");

  // only reads return cell data, and reads never scroll
  a_cell_noscroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_value_o != '0) |-> !scrolled_o)
    else $error("cell value together with scroll");

  // read beat result follows acceptance through the T_READ state and the output register
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_READ) |-> ##2 out_valid_o)
    else $error("read result late");

  // clearing pass after reset blocks input
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && !$past(rst_ni) |-> in_stall_o)
    else $error("input taken during power-up fill");

endmodule

bind text_terminal_cursor_scroll ttcs_checker u_ttcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .func_i          (func_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cursor_column_o (cursor_column_o),
  .cell_value_o    (cell_value_o),
  .scrolled_o      (scrolled_o)
);

@@ bench/text_terminal_cursor_scroll_tb.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_tb: self-checking bench for the text terminal
// Drives put, clear, read and unused operations with random gaps on both
// channels, keeps its own screen, cursor and color model, and compares every
// output beat field by field against the oldest predicted result. Phases run
// with different text colors, written over the config channel while idle.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcs_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int LIMIT = 20_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_OPS = 220;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } term_op_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [CELL_W-1:0]    cell_val;
    logic                 scrolled;
  } term_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [COLOR_W-1:0]   cfg_text_color_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [FUNC_W-1:0]    func_i = '0;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [IDX_W-1:0]     cell_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ROW_OUT_W-1:0] cursor_row_o;
  logic [COL_OUT_W-1:0] cursor_column_o;
  logic [CELL_W-1:0]    cell_value_o;
  logic                 scrolled_o;

  // bench model of the block
  logic [CELL_W-1:0]  screen_model [CELLS];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] txt_color;

  term_op_t     pending_ops_q [$];
  term_result_t term_result_q [$];
  int           ops_in_flight = 0;
  int           err_count = 0;
  int           cycle_cnt = 0;

  // generator-side cursor, used only to steer stimulus
  int gen_row = 0;
  int gen_col = 0;
  int scroll_budget = 0;

  logic idle_in = 1'b0;
  logic idle_out = 1'b0;

  // driver / monitor variables
  term_op_t     next_op;
  logic         next_valid;
  int           send_gap = 0;
  term_result_t want;
  logic         next_stall;
  int           rx_wait = 0;

  text_terminal_cursor_scroll #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_text_color_i(cfg_text_color_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .cell_index_i    (cell_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .cell_value_o    (cell_value_o),
    .scrolled_o      (scrolled_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic apply_terminal_op(input term_op_t op);
    term_result_t r;
    int i;
    r = '0;
    case (op.func)
      FUNC_PUT: begin
        if (op.ch == NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          if (cur_row < ROWS && cur_col < COLS)
            screen_model[cur_row * COLS + cur_col] = {txt_color, op.ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {txt_color, BLANK_CODE};
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = {txt_color, BLANK_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      FUNC_READ: begin
        if (op.idx < CELLS) r.cell_val = screen_model[op.idx];
      end
      default: ;
    endcase
    r.row = cur_row[ROW_OUT_W-1:0];
    r.col = cur_col[COL_OUT_W-1:0];
    term_result_q.push_back(r);
  endtask

  task automatic push_op(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                         input logic [IDX_W-1:0] x);
    term_op_t op;
    op.func = f;
    op.ch   = c;
    op.idx  = x;
    pending_ops_q.push_back(op);
    ops_in_flight++;
    if (f == FUNC_PUT) begin
      if (c == NEWLINE_CODE) begin
        gen_col = 0;
        gen_row++;
      end else begin
        gen_col++;
        if (gen_col == COLS) begin
          gen_col = 0;
          gen_row++;
        end
      end
      if (gen_row == ROWS) begin
        gen_row = ROWS - 1;
        if (scroll_budget > 0) scroll_budget--;
      end
    end else if (f == FUNC_CLEAR) begin
      gen_row = 0;
      gen_col = 0;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (ops_in_flight != 0);
  endtask

  task automatic write_text_color(input logic [COLOR_W-1:0] c);
    @(posedge clk_i);
    cfg_text_color_i <= c;
    cfg_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    txt_color = c;
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        next_op.func = func_i;
        next_op.ch   = char_code_i;
        next_op.idx  = cell_index_i;
        apply_terminal_op(next_op);
        send_gap   = idle_in ? $urandom_range(0, 15) : 0;
        next_valid = 1'b0;
      end else begin
        next_valid = in_valid_i;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops_q.size() > 0) begin
          next_op = pending_ops_q.pop_front();
          func_i       <= next_op.func;
          char_code_i  <= next_op.ch;
          cell_index_i <= next_op.idx;
          next_valid   = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (term_result_q.size() == 0) begin
          report_mismatch("output beat with no pending operation");
        end else begin
          want = term_result_q.pop_front();
          if (cursor_row_o !== want.row)
            report_mismatch($sformatf("cursor_row got %0d want %0d", cursor_row_o, want.row));
          if (cursor_column_o !== want.col)
            report_mismatch($sformatf("cursor_column got %0d want %0d",
                                      cursor_column_o, want.col));
          if (cell_value_o !== want.cell_val)
            report_mismatch($sformatf("cell_value got %h want %h", cell_value_o,
                                      want.cell_val));
          if (scrolled_o !== want.scrolled)
            report_mismatch($sformatf("scrolled got %b want %b", scrolled_o, want.scrolled));
          ops_in_flight--;
        end
        rx_wait = idle_out ? $urandom_range(0, 15) : 0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    int ph;
    int n;
    int sel;
    int nl_pct;
    logic [COLOR_W-1:0] pc;
    logic [CHAR_W-1:0]  ch;
    logic [IDX_W-1:0]   idx;

    for (i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;
    cur_row   = 0;
    cur_col   = 0;
    txt_color = COLOR_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, range edges, extremes, newline, unused func
    push_op(FUNC_READ, 8'h00, 11'd0);
    push_op(FUNC_READ, 8'hFF, 11'd1999);
    push_op(FUNC_READ, 8'h00, 11'd2000);
    push_op(FUNC_READ, 8'h00, 11'h7FF);
    push_op(FUNC_NOP, 8'hFF, 11'h7FF);
    push_op(FUNC_PUT, 8'h41, 11'h7FF);
    push_op(FUNC_PUT, 8'h00, 11'd0);
    push_op(FUNC_PUT, 8'hFF, 11'd0);
    push_op(FUNC_PUT, NEWLINE_CODE, 11'd0);
    push_op(FUNC_PUT, 8'h7E, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd2);
    push_op(FUNC_READ, 8'h00, 11'd3);
    push_op(FUNC_READ, 8'h00, 11'd80);
    push_op(FUNC_READ, 8'h00, 11'd81);
    push_op(FUNC_CLEAR, 8'h00, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd0);
    push_op(FUNC_NOP, 8'h00, 11'd0);
    wait_drained();
    write_text_color(8'h00);
    push_op(FUNC_PUT, 8'h78, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd0);
    wait_drained();
    write_text_color(8'hFF);
    push_op(FUNC_CLEAR, 8'h00, 11'd0);
    push_op(FUNC_PUT, 8'h55, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd0);
    push_op(FUNC_READ, 8'h00, 11'd1999);

    // random phases
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: pc = 8'h00;
        3: pc = 8'hFF;
        7: pc = COLOR_RESET;
        default: pc = COLOR_W'($urandom_range(0, 255));
      endcase
      write_text_color(pc);
      scroll_budget = 25;
      case (ph == 0 ? 3 : $urandom_range(0, 2))
        0: nl_pct = 2;
        1: nl_pct = 8;
        2: nl_pct = 25;
        default: nl_pct = 40;
      endcase
      for (n = 0; n < PHASE_OPS; n++) begin
        if (n % 40 == 0) begin
          idle_in  = $urandom_range(0, 3) != 0;
          idle_out = $urandom_range(0, 3) != 0;
        end
        sel = $urandom_range(0, 99);
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = IDX_W'($urandom_range(0, 2047));
        if (gen_row == ROWS - 1 && scroll_budget == 0) begin
          push_op(FUNC_CLEAR, ch, idx);
        end else if (sel < 2) begin
          push_op(FUNC_CLEAR, ch, idx);
        end else if (sel < 5) begin
          push_op(FUNC_NOP, ch, idx);
        end else if (sel < 35) begin
          case ($urandom_range(0, 9))
            0:       idx = IDX_W'($urandom_range(CELLS, 2047));
            1, 2, 3: idx = IDX_W'($urandom_range(0, CELLS - 1));
            default: idx = IDX_W'(gen_row * COLS + $urandom_range(0, COLS - 1));
          endcase
          push_op(FUNC_READ, ch, idx);
        end else begin
          if ($urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
          push_op(FUNC_PUT, ch, idx);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (term_result_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", term_result_q.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
